[design/tle_pkg.sv]
`timescale 1ns / 1ps

package tle_pkg;

  // Largest line the buffer behind this block can take.
  localparam int LINE_MAX = 256;
  localparam int TOP_LIMIT_INT = (LINE_MAX < 256) ? LINE_MAX : 256;
  localparam logic [8:0] TOP_LIMIT = TOP_LIMIT_INT[8:0];

  localparam logic [7:0] KEY_CR  = 8'h0d;
  localparam logic [7:0] KEY_LF  = 8'h0a;
  localparam logic [7:0] KEY_DEL = 8'h7f;
  localparam logic [7:0] KEY_BS  = 8'h08;
  localparam logic [7:0] KEY_SP  = 8'h20;

  localparam int TDATA_W = 40;
  localparam int TUSER_W = 3;

  // Index of each flag in the output tuser.
  localparam int USER_ECHO  = 0;
  localparam int USER_STORE = 1;
  localparam int USER_DONE  = 2;

  typedef enum logic [1:0] {
    KIND_CHAR    = 2'd0,
    KIND_NEWLINE = 2'd1,
    KIND_ERASE   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    STEP_FIRST  = 3'b001,
    STEP_SECOND = 3'b010,
    STEP_THIRD  = 3'b100
  } step_t;

  // One decoded byte waiting for its echo beats.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] chr;
    logic [7:0] pos;
    logic       done;
    logic [8:0] len;
  } item_t;

endpackage

[design/terminal_line_editor_echo.sv]
`timescale 1ns / 1ps

// Line editor for a terminal receive path: each received byte beat produces its echo
// beats and buffer writes. CR or LF gives two beats (CR echo, then LF echo with the newline
// store and the end of the line), DEL on a non-empty line gives three beats (BS, space, BS),
// DEL on an empty line gives none and any other byte gives one beat that stores it and ends
// the line when the count reaches the limit. A byte is taken into a decode register, and
// the output register then sends one beat per cycle while out_tready does not stall it. A
// new byte is taken in the same cycle the last beat of the previous one moves into the
// output register, which happens only when that register is empty or hands its beat over
// in the same cycle, so a stalled output holds off the input. The line limit is to be
// written through cfg_we and cfg_wdata only while the block is idle, which the block
// itself does not enforce; a value of zero acts as one and values above the buffer size
// act as the buffer size.

module terminal_line_editor_echo
  import tle_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,    // [7:0] rx_byte
  output logic               out_tvalid,
  input  logic               out_tready,
  // [7:0] echo_char, [15:8] store_index, [23:16] store_char, [32:24] line_length, rest zero
  output logic [TDATA_W-1:0] out_tdata,
  output logic [TUSER_W-1:0] out_tuser,   // [0] echo_valid, [1] store_valid, [2] line_done
  output logic               out_tlast,
  input  logic               cfg_we,
  input  logic [8:0]         cfg_wdata
);

  logic [8:0] limit_r, limit_nxt;
  logic       slot_free;
  logic       item_valid;
  item_t      item;

  // The limit is clamped once at write time so the decode path sees a legal value.
  always_comb begin
    limit_nxt = limit_r;
    if (cfg_we) begin
      if (cfg_wdata == 9'd0) begin
        limit_nxt = 9'd1;
      end else if (cfg_wdata > TOP_LIMIT) begin
        limit_nxt = TOP_LIMIT;
      end else begin
        limit_nxt = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= TOP_LIMIT;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  // Decode stage: tracks the character count and holds one decoded byte.
  tle_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .limit      (limit_r),
    .slot_free  (slot_free),
    .item_valid (item_valid),
    .item       (item)
  );

  // Beat sequencer and output register.
  tle_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .slot_free  (slot_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  // A finished line is always the store beat that closes the byte's beats.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[USER_DONE] |-> out_tlast && out_tuser[USER_STORE])
    else $error("line end without store or before the final beat");

  // Length is only reported on the beat that ends a line.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[USER_DONE] |-> out_tdata[32:24] == 9'd0)
    else $error("line length on a beat that does not end a line");

  // The stored limit always stays in the legal range.
  assert property (@(posedge clk) disable iff (!rst_n)
    limit_r != 9'd0 && limit_r <= TOP_LIMIT)
    else $error("line limit out of range");

  // An accepted CR is held as a newline item in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata == KEY_CR |=> item_valid && item.kind == KIND_NEWLINE)
    else $error("accepted CR not decoded as a newline");
`endif

endmodule

[design/tle_front.sv]
`timescale 1ns / 1ps

module tle_front
  import tle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic [8:0] limit,
  input  logic       slot_free,
  output logic       item_valid,
  output item_t      item
);

  logic [7:0] count_r, count_nxt;
  logic       item_valid_r, item_valid_nxt;
  item_t      item_r, item_nxt;
  logic       accept;
  logic [8:0] next_len;
  logic       hit_limit;

  assign in_tready  = slot_free;
  assign accept     = in_tvalid && slot_free;
  assign next_len   = {1'b0, count_r} + 9'd1;
  assign hit_limit  = next_len >= limit;
  assign item_valid = item_valid_r;
  assign item       = item_r;

  always_comb begin
    count_nxt      = count_r;
    item_valid_nxt = slot_free ? 1'b0 : item_valid_r;
    item_nxt       = item_r;
    if (accept) begin
      item_nxt.chr = in_tdata;
      item_nxt.pos = count_r;
      if (in_tdata inside {KEY_CR, KEY_LF}) begin
        item_nxt.kind  = KIND_NEWLINE;
        item_nxt.done  = 1'b1;
        item_nxt.len   = next_len;
        item_valid_nxt = 1'b1;
        count_nxt      = '0;
      end else if (in_tdata == KEY_DEL) begin
        // Erasing on an empty line gives no beats at all.
        item_nxt.kind = KIND_ERASE;
        item_nxt.done = 1'b0;
        item_nxt.len  = '0;
        if (count_r != '0) begin
          item_valid_nxt = 1'b1;
          count_nxt      = count_r - 8'd1;
        end
      end else begin
        item_nxt.kind  = KIND_CHAR;
        item_nxt.done  = hit_limit;
        item_nxt.len   = hit_limit ? next_len : 9'd0;
        item_valid_nxt = 1'b1;
        count_nxt      = hit_limit ? 8'd0 : next_len[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      item_valid_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      item_valid_r <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

[design/tle_emit.sv]
`timescale 1ns / 1ps

module tle_emit
  import tle_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  item_t              item,
  output logic               slot_free,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,
  output logic [TUSER_W-1:0] out_tuser,
  output logic               out_tlast
);

  step_t              step_r, step_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [TDATA_W-1:0] data_r, data_nxt;
  logic [TUSER_W-1:0] user_r, user_nxt;
  logic               last_r, last_nxt;
  logic               fire;
  logic [7:0]         echo_char;
  logic               store_valid;
  logic               line_done;
  logic [8:0]         line_length;
  logic               final_beat;

  assign fire      = item_valid && (!out_valid_r || out_tready);
  assign slot_free = !item_valid || (fire && final_beat);

  always_comb begin
    echo_char   = item.chr;
    store_valid = 1'b0;
    line_done   = 1'b0;
    line_length = '0;
    final_beat  = 1'b1;
    case (item.kind)
      KIND_NEWLINE: begin
        if (step_r == STEP_FIRST) begin
          echo_char  = KEY_CR;
          final_beat = 1'b0;
        end else begin
          echo_char   = KEY_LF;
          store_valid = 1'b1;
          line_done   = 1'b1;
          line_length = item.len;
        end
      end
      KIND_ERASE: begin
        echo_char  = (step_r == STEP_SECOND) ? KEY_SP : KEY_BS;
        final_beat = (step_r == STEP_THIRD);
      end
      KIND_CHAR: begin
        store_valid = 1'b1;
        line_done   = item.done;
        line_length = item.len;
      end
      default: begin
        final_beat = 1'b1;
      end
    endcase
  end

  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_tready;
    data_nxt      = data_r;
    user_nxt      = user_r;
    last_nxt      = last_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
      data_nxt = {7'd0, line_length,
                  store_valid ? (item.kind == KIND_NEWLINE ? KEY_LF : item.chr) : 8'd0,
                  store_valid ? item.pos : 8'd0,
                  echo_char};
      user_nxt = {line_done, store_valid, 1'b1};
      last_nxt = final_beat;
      case (step_r)
        STEP_FIRST:  step_nxt = final_beat ? STEP_FIRST : STEP_SECOND;
        STEP_SECOND: step_nxt = final_beat ? STEP_FIRST : STEP_THIRD;
        default:     step_nxt = STEP_FIRST;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    user_r <= user_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule

[bench/terminal_line_editor_echo_test.sv]
`timescale 1ns / 1ps

// The bench drives received bytes into the line editor and predicts every echo beat.
// Inputs change on the falling clock edge and outputs are sampled on the rising edge,
// so no check depends on the order of events inside a time step. The predictor keeps its
// own copy of the character count and the line limit. It runs at the edge where a byte is
// accepted and queues the beats that byte must cause. A monitor process pops one
// expectation for every output beat and compares it field by field.

module terminal_line_editor_echo_test;
  import tle_pkg::*;

  // One echo beat, split into the fields the block packs into tdata, tuser and tlast.
  typedef struct {
    logic       echo_valid;
    logic [7:0] echo_char;
    logic       store_valid;
    logic [7:0] store_index;
    logic [7:0] store_char;
    logic       line_done;
    logic [8:0] line_length;
    logic       last;
  } beat_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic [7:0]         in_tdata   = 8'h00;
  logic               out_tready = 1'b0;
  logic               cfg_we     = 1'b0;
  logic [8:0]         cfg_wdata  = 9'd0;
  logic               in_tready;
  logic               out_tvalid;
  logic [TDATA_W-1:0] out_tdata;
  logic [TUSER_W-1:0] out_tuser;
  logic               out_tlast;

  // These are the echo beats still owed by the block, oldest first.
  beat_t      echo_beats_owed[$];
  // This is the predictor's copy of the block state and of its one register.
  logic [8:0] line_chars = 9'd0;
  logic [8:0] limit_reg  = 9'd256;
  // While steady is set, neither side idles. This gives stretches at full rate.
  bit         steady     = 1'b0;

  int mismatches   = 0;
  int keys_taken   = 0;
  int keys_echoed  = 0;
  int beats_seen   = 0;
  int lines_closed = 0;

  terminal_line_editor_echo u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // This is a hard limit on the run. A correct run needs far less than this time, even
  // when the random stalls are at their worst.
  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

  function automatic beat_t make_beat(input logic [7:0] echo, input logic sv,
                                      input logic [7:0] si, input logic [7:0] sc,
                                      input logic done, input logic [8:0] len,
                                      input logic lst);
    beat_t b;
    b.echo_valid  = 1'b1;   // Every beat this block makes carries an echo.
    b.echo_char   = echo;
    b.store_valid = sv;
    b.store_index = si;
    b.store_char  = sc;
    b.line_done   = done;
    b.line_length = len;
    b.last        = lst;
    return b;
  endfunction

  // Work out the beats that one accepted byte causes, and move the line count on.
  function automatic void edit_line(input logic [7:0] key);
    logic [8:0] lim;
    logic [8:0] nxt;
    // A limit of zero behaves as one, and anything above the buffer size is clipped.
    lim = limit_reg;
    if (lim == 9'd0) lim = 9'd1;
    if (lim > TOP_LIMIT) lim = TOP_LIMIT;
    if (key == KEY_CR || key == KEY_LF) begin
      // A newline echoes CR, then LF. The LF beat also stores the newline and ends the line.
      echo_beats_owed.push_back(make_beat(KEY_CR, 1'b0, 8'h00, 8'h00, 1'b0, 9'd0, 1'b0));
      echo_beats_owed.push_back(make_beat(KEY_LF, 1'b1, line_chars[7:0], KEY_LF, 1'b1,
                                          line_chars + 9'd1, 1'b1));
      line_chars = 9'd0;
      keys_echoed++;
    end else if (key == KEY_DEL) begin
      // An erase on an empty line is swallowed with no beat at all.
      if (line_chars != 9'd0) begin
        echo_beats_owed.push_back(make_beat(KEY_BS, 1'b0, 8'h00, 8'h00, 1'b0, 9'd0, 1'b0));
        echo_beats_owed.push_back(make_beat(KEY_SP, 1'b0, 8'h00, 8'h00, 1'b0, 9'd0, 1'b0));
        echo_beats_owed.push_back(make_beat(KEY_BS, 1'b0, 8'h00, 8'h00, 1'b0, 9'd0, 1'b1));
        line_chars = line_chars - 9'd1;
        keys_echoed++;
      end
    end else begin
      // An ordinary byte is stored at the current position. The line ends once the new
      // count reaches the limit, and this also holds when the limit was lowered under a
      // longer line.
      nxt = line_chars + 9'd1;
      if (nxt >= lim) begin
        echo_beats_owed.push_back(make_beat(key, 1'b1, line_chars[7:0], key, 1'b1, nxt, 1'b1));
        line_chars = 9'd0;
      end else begin
        echo_beats_owed.push_back(make_beat(key, 1'b1, line_chars[7:0], key, 1'b0, 9'd0,
                                            1'b1));
        line_chars = nxt;
      end
      keys_echoed++;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic match_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  // The monitor takes every beat the block hands over and checks it against the oldest
  // expectation. The values are read at the rising edge, before that edge updates them.
  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      beats_seen++;
      if (out_tuser[USER_DONE]) lines_closed++;
      if (echo_beats_owed.size() == 0) begin
        report_mismatch($sformatf("beat with nothing owed, echo 0x%0h", out_tdata[7:0]));
      end else begin
        want = echo_beats_owed.pop_front();
        match_field("echo_valid",  out_tuser[USER_ECHO],  want.echo_valid);
        match_field("echo_char",   out_tdata[7:0],        want.echo_char);
        match_field("store_valid", out_tuser[USER_STORE], want.store_valid);
        match_field("store_index", out_tdata[15:8],       want.store_index);
        match_field("store_char",  out_tdata[23:16],      want.store_char);
        match_field("line_done",   out_tuser[USER_DONE],  want.line_done);
        match_field("line_length", out_tdata[32:24],      want.line_length);
        match_field("tdata pad",   out_tdata[TDATA_W-1:33], 0);
        match_field("tlast",       out_tlast,             want.last);
      end
    end
  end

  // The receiver stalls about 13 percent of the time, except while steady is set.
  initial begin
    forever begin
      @(negedge clk);
      out_tready = steady || ($urandom_range(0, 99) >= 13);
    end
  end

  // Send one byte beat. The task starts and ends on a falling edge, with valid low at the
  // end. The next call may raise valid again in the same time step. These are blocking
  // assignments, so only the final value is seen at the rising edge that follows.
  task automatic send_key(input logic [7:0] key);
    while (!steady && $urandom_range(0, 99) < 13) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = key;
    do @(posedge clk); while (!in_tready);
    edit_line(key);
    keys_taken++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Wait until every owed beat has arrived and let the clock run on after that. The task
  // returns on a falling edge.
  task automatic settle();
    while (echo_beats_owed.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  // Write the line limit while the block is idle. The predictor follows after the edge.
  task automatic write_limit(input logic [8:0] value);
    settle();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    limit_reg = value;
  endtask

  // Editing at the reset limit: typing, erase, erase on an empty line, both newline keys,
  // an empty line, and the byte extremes.
  task automatic test_basic_editing();
    send_key(8'h68);
    send_key(8'h69);
    send_key(KEY_DEL);
    send_key(KEY_DEL);
    send_key(KEY_DEL);      // The line is already empty, so this byte makes no beat.
    send_key(8'h00);
    send_key(8'hff);
    send_key(8'h80);
    send_key(KEY_BS);       // BS and space are typed as ordinary bytes.
    send_key(KEY_SP);
    send_key(KEY_CR);
    send_key(KEY_LF);       // This LF ends an empty line, which has length one.
  endtask

  // These are the smallest limits: one, and zero, which behaves as one.
  task automatic test_limit_edges();
    write_limit(9'd1);
    send_key(8'h61);
    send_key(8'h62);
    send_key(KEY_DEL);
    send_key(KEY_CR);
    write_limit(9'd0);
    send_key(8'h7e);
    send_key(8'h01);
  endtask

  // Lower the limit under a line that is already longer than the new limit.
  task automatic test_lowered_limit();
    write_limit(9'd256);
    repeat (5) send_key(8'($urandom_range(8'h21, 8'h7e)));
    write_limit(9'd3);
    send_key(8'h66);        // The count is already past the limit, so the line ends here.
    repeat (3) send_key(8'($urandom_range(8'h21, 8'h7e)));
  endtask

  // A long line at full rate. A limit above 256 behaves as 256, so the line stays open.
  task automatic test_long_line();
    write_limit(9'd300);
    steady = 1'b1;
    repeat (60) send_key(8'($urandom_range(8'h21, 8'h7e)));
    steady = 1'b0;
  endtask

  // Random traffic. Most of it is typed lines with erases and a newline at the end. The
  // rest is erase bursts and raw bytes of any value.
  task automatic type_random(input int quota);
    int start;
    int dice;
    start = keys_echoed;
    while (keys_echoed - start < quota) begin
      dice = $urandom_range(0, 99);
      if (dice < 70) begin
        repeat ($urandom_range(1, 12)) begin
          if ($urandom_range(0, 9) == 0) send_key(KEY_DEL);
          else if ($urandom_range(0, 5) == 0) send_key(KEY_SP);
          else send_key(8'($urandom_range(8'h21, 8'h7e)));
        end
        send_key($urandom_range(0, 1) ? KEY_CR : KEY_LF);
      end else if (dice < 85) begin
        repeat ($urandom_range(1, 6)) send_key(KEY_DEL);
      end else begin
        send_key(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Random phases under several limits, the extremes among them.
  task automatic test_random_phases();
    logic [8:0] limits [7];
    limits = '{9'd256, 9'd4, 9'd1, 9'd0, 9'd23, 9'd511, 9'd0};
    limits[6] = 9'($urandom_range(2, 80));
    for (int p = 0; p < 7; p++) begin
      write_limit(limits[p]);
      steady = (p == 4);
      type_random(18);
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_basic_editing();
    test_limit_edges();
    test_lowered_limit();
    test_long_line();
    test_random_phases();

    settle();
    repeat (10) @(posedge clk);

    $display("covered %0d bytes (%0d echoed), %0d beats, %0d lines ended",
             keys_taken, keys_echoed, beats_seen, lines_closed);
    $display("limits 0, 1, 3, 4, 23, 256, 300, 511 and a random one, with a long full-rate line");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
